FILE: src/bbc_pkg.sv
// ----------------------------------------------------------------------------
// bbc_pkg
// Shared types, character codes and decode helpers for the bracket checker.
// ----------------------------------------------------------------------------
`default_nettype none

package bbc_pkg;

   // default stack depth and field widths
   localparam int STACK_DEPTH_DEFAULT = 64;
   localparam int DEPTH_W             = 7;
   localparam int DEPTH_SAT           = (2 ** DEPTH_W) - 1;
   localparam int BYTE_W              = 8;
   localparam int REQ_TDATA_W         = 8;
   localparam int RSP_TDATA_W         = 16;

   // configuration port geometry
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_IDX_W  = CSR_ADDR_W - 2;
   localparam logic [CSR_IDX_W-1:0] REG_SQUARE_ENABLED = '0;

   // bracket characters
   localparam logic [BYTE_W-1:0] CHAR_ROUND_OPEN   = 8'h28;
   localparam logic [BYTE_W-1:0] CHAR_ROUND_CLOSE  = 8'h29;
   localparam logic [BYTE_W-1:0] CHAR_SQUARE_OPEN  = 8'h5B;
   localparam logic [BYTE_W-1:0] CHAR_SQUARE_CLOSE = 8'h5D;
   localparam logic [BYTE_W-1:0] CHAR_CURLY_OPEN   = 8'h7B;
   localparam logic [BYTE_W-1:0] CHAR_CURLY_CLOSE  = 8'h7D;

   typedef enum logic [1:0] {
      KIND_ROUND  = 2'd0,
      KIND_SQUARE = 2'd1,
      KIND_CURLY  = 2'd2,
      KIND_NONE   = 2'd3
   } kind_type;

   typedef enum logic [2:0] {
      STATUS_OK        = 3'd0,
      STATUS_MISMATCH  = 3'd1,
      STATUS_UNMATCHED = 3'd2,
      STATUS_UNCLOSED  = 3'd3,
      STATUS_OVERFLOW  = 3'd4,
      STATUS_BALANCED  = 3'd5
   } status_type;

   // one text byte as held in the input register
   typedef struct packed {
      logic [BYTE_W-1:0] byte_value;
      logic              end_of_text;
   } item_type;

   // one result as held in the output register
   typedef struct packed {
      status_type         status;
      logic [DEPTH_W-1:0] nesting_depth;
   } result_type;

   // kind of an opening bracket, or none
   function automatic kind_type opener_kind(input logic [BYTE_W-1:0] b,
                                            input logic square_en);
      kind_type k;
      k = KIND_NONE;
      case (b)
         CHAR_ROUND_OPEN:  k = KIND_ROUND;
         CHAR_CURLY_OPEN:  k = KIND_CURLY;
         CHAR_SQUARE_OPEN: k = square_en ? KIND_SQUARE : KIND_NONE;
         default:          k = KIND_NONE;
      endcase
      return k;
   endfunction

   // kind of a closing bracket, or none
   function automatic kind_type closer_kind(input logic [BYTE_W-1:0] b,
                                            input logic square_en);
      kind_type k;
      k = KIND_NONE;
      case (b)
         CHAR_ROUND_CLOSE:  k = KIND_ROUND;
         CHAR_CURLY_CLOSE:  k = KIND_CURLY;
         CHAR_SQUARE_CLOSE: k = square_en ? KIND_SQUARE : KIND_NONE;
         default:           k = KIND_NONE;
      endcase
      return k;
   endfunction

endpackage

`default_nettype wire

FILE: src/bbc_csr.sv
// ----------------------------------------------------------------------------
// bbc_csr
// Configuration register bank behind an APB-style port.
// ----------------------------------------------------------------------------
`default_nettype none

module bbc_csr (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             csr_psel,
   input  wire logic                             csr_penable,
   input  wire logic                             csr_pwrite,
   input  wire logic [bbc_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  wire logic [bbc_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic      [bbc_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                                  csr_pready,
   output logic                                  square_enabled
);
   import bbc_pkg::*;

   logic                 square_en_ff;
   logic                 square_en_in;
   logic [CSR_IDX_W-1:0] reg_index;
   logic                 wr_transfer;

   assign csr_pready  = 1'b1;
   assign reg_index   = csr_paddr[CSR_ADDR_W-1:2];
   assign wr_transfer = csr_psel & csr_penable & csr_pwrite & csr_pready;

   // register write decode
   always_comb begin
      square_en_in = square_en_ff;
      if (wr_transfer && (reg_index == REG_SQUARE_ENABLED)) begin
         square_en_in = csr_pwdata[0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         square_en_ff <= 1'b1;
      end else begin
         square_en_ff <= square_en_in;
      end
   end

   // read-back mux
   always_comb begin
      csr_prdata = '0;
      if (reg_index == REG_SQUARE_ENABLED) begin
         csr_prdata = {{(CSR_DATA_W-1){1'b0}}, square_en_ff};
      end
   end

   assign square_enabled = square_en_ff;

endmodule

`default_nettype wire

FILE: src/bbc_in_reg.sv
// ----------------------------------------------------------------------------
// bbc_in_reg
// Input register stage for incoming text bytes.
// ----------------------------------------------------------------------------
`default_nettype none

module bbc_in_reg (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   input  wire logic [bbc_pkg::REQ_TDATA_W-1:0]   req_tdata,
   input  wire logic                              req_tlast,
   input  wire logic                              advance,
   output logic                                   item_valid,
   output bbc_pkg::item_type                      item
);
   import bbc_pkg::*;

   logic     valid_ff;
   logic     valid_in;
   item_type item_ff;

   // stage is free when empty or when its byte moves on this cycle
   assign req_tready = !valid_ff || advance;

   always_comb begin
      valid_in = valid_ff;
      if (req_tready) begin
         valid_in = req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // payload, no reset
   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         item_ff.byte_value  <= req_tdata[BYTE_W-1:0];
         item_ff.end_of_text <= req_tlast;
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

`default_nettype wire

FILE: src/bbc_engine.sv
// ----------------------------------------------------------------------------
// bbc_engine
// Bracket stack, sticky error and per-byte verdict logic.
// ----------------------------------------------------------------------------
`default_nettype none

module bbc_engine #(
   parameter int STACK_DEPTH = bbc_pkg::STACK_DEPTH_DEFAULT
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                step_en,
   input  wire bbc_pkg::item_type   item,
   input  wire logic                square_enabled,
   output bbc_pkg::result_type      result
);
   import bbc_pkg::*;

   localparam int CNT_W  = $clog2(STACK_DEPTH + 1);
   localparam int ADDR_W = $clog2(STACK_DEPTH);
   localparam logic [CNT_W-1:0] FULL = CNT_W'(STACK_DEPTH);

   // stack entries; the top entry is also kept in top_ff, and the entry
   // just below it is prefetched into below_ff so a pop never waits for a read
   kind_type kind_mem [STACK_DEPTH];

   logic [CNT_W-1:0]  count_ff;
   logic [CNT_W-1:0]  count_in;
   logic [CNT_W-1:0]  proc_count;
   status_type        err_ff;
   status_type        err_in;
   status_type        proc_err;
   kind_type          top_ff;
   kind_type          top_in;
   kind_type          below_ff;
   kind_type          open_k;
   kind_type          close_k;
   logic              push;
   logic [ADDR_W-1:0] wr_addr;
   logic [ADDR_W-1:0] rd_addr;
   logic [CNT_W-1:0]  rd_count;
   logic [31:0]       depth_wide;

   assign open_k  = opener_kind(item.byte_value, square_enabled);
   assign close_k = closer_kind(item.byte_value, square_enabled);

   // push, pop and error detection for one byte
   always_comb begin
      proc_count = count_ff;
      proc_err   = err_ff;
      top_in     = top_ff;
      push       = 1'b0;
      if (step_en && (err_ff == STATUS_OK)) begin
         if (open_k != KIND_NONE) begin
            if (count_ff >= FULL) begin
               proc_err = STATUS_OVERFLOW;
            end else begin
               push       = 1'b1;
               top_in     = open_k;
               proc_count = count_ff + CNT_W'(1);
            end
         end else if (close_k != KIND_NONE) begin
            if (count_ff == '0) begin
               proc_err = STATUS_UNMATCHED;
            end else if (top_ff != close_k) begin
               proc_err = STATUS_MISMATCH;
            end else begin
               proc_count = count_ff - CNT_W'(1);
               top_in     = below_ff;
            end
         end
      end
   end

   // reported depth saturates at the field's maximum
   assign depth_wide = 32'(proc_count);

   // verdict and self-clear at the end of the text
   always_comb begin
      result.status = proc_err;
      if (item.end_of_text && (proc_err == STATUS_OK)) begin
         result.status = (proc_count != '0) ? STATUS_UNCLOSED : STATUS_BALANCED;
      end
      result.nesting_depth = (depth_wide > 32'(DEPTH_SAT)) ?
                             DEPTH_W'(DEPTH_SAT) : depth_wide[DEPTH_W-1:0];
      count_in = proc_count;
      err_in   = proc_err;
      if (step_en && item.end_of_text) begin
         count_in = '0;
         err_in   = STATUS_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         err_ff   <= STATUS_OK;
      end else begin
         count_ff <= count_in;
         err_ff   <= err_in;
      end
   end

   always_ff @(posedge clock) begin
      top_ff <= top_in;
   end

   // stack memory: write the new top, prefetch the entry under the next top
   assign wr_addr  = count_ff[ADDR_W-1:0];
   assign rd_count = count_in - CNT_W'(2);
   assign rd_addr  = rd_count[ADDR_W-1:0];

   always_ff @(posedge clock) begin
      if (push) begin
         kind_mem[wr_addr] <= open_k;
      end
      below_ff <= kind_mem[rd_addr];
   end

endmodule

`default_nettype wire

FILE: src/bbc_out_reg.sv
// ----------------------------------------------------------------------------
// bbc_out_reg
// Result register stage driving the result stream.
// ----------------------------------------------------------------------------
`default_nettype none

module bbc_out_reg (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              in_valid,
   input  wire bbc_pkg::result_type               result,
   output logic                                   advance,
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   output logic      [bbc_pkg::RSP_TDATA_W-1:0]   rsp_tdata
);
   import bbc_pkg::*;

   localparam int PAD_W = RSP_TDATA_W - 3 - DEPTH_W;

   logic       valid_ff;
   logic       valid_in;
   result_type result_ff;

   // register takes a new result when empty or when the held one leaves
   assign advance = !valid_ff || rsp_tready;

   always_comb begin
      valid_in = valid_ff;
      if (advance) begin
         valid_in = in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && in_valid) begin
         result_ff <= result;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {{PAD_W{1'b0}}, result_ff.nesting_depth, result_ff.status};

endmodule

`default_nettype wire

FILE: src/bracket_balance_checker_core.sv
// ----------------------------------------------------------------------------
// bracket_balance_checker_core
// Streaming checker for nesting and matching of (), [] and {} in a text.
// ----------------------------------------------------------------------------
// Takes one text byte per clock unless the results stall and returns one
// result per byte, in order. Each result carries the sticky status of the
// text so far and the count of open brackets; the byte marked by tlast gives
// the final verdict and clears the checker for the next text. The one-byte
// rate is held by keeping the top of the bracket stack in a register and
// prefetching the entry below it from the stack memory's registered read
// port, so a pop never waits for a read. Square brackets are checked only
// while square_enabled is set; change it only while no byte is in flight.
`default_nettype none

module bracket_balance_checker_core #(
   parameter int STACK_DEPTH = bbc_pkg::STACK_DEPTH_DEFAULT
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   // req_tdata: [7:0] byte_value; req_tlast: end_of_text
   input  wire logic                             req_tvalid,
   output logic                                  req_tready,
   input  wire logic [bbc_pkg::REQ_TDATA_W-1:0]  req_tdata,
   input  wire logic                             req_tlast,
   // rsp_tdata: [2:0] status, [9:3] nesting_depth, [15:10] zero
   output logic                                  rsp_tvalid,
   input  wire logic                             rsp_tready,
   output logic      [bbc_pkg::RSP_TDATA_W-1:0]  rsp_tdata,
   input  wire logic                             csr_psel,
   input  wire logic                             csr_penable,
   input  wire logic                             csr_pwrite,
   input  wire logic [bbc_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  wire logic [bbc_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic      [bbc_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                                  csr_pready
);
   import bbc_pkg::*;

   logic       square_enabled;
   logic       item_valid;
   item_type   item;
   logic       advance;
   logic       step_en;
   result_type result;

   bbc_csr u_csr (
      .clock          (clock),
      .reset          (reset),
      .csr_psel       (csr_psel),
      .csr_penable    (csr_penable),
      .csr_pwrite     (csr_pwrite),
      .csr_paddr      (csr_paddr),
      .csr_pwdata     (csr_pwdata),
      .csr_prdata     (csr_prdata),
      .csr_pready     (csr_pready),
      .square_enabled (square_enabled)
   );

   bbc_in_reg u_in_reg (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .advance    (advance),
      .item_valid (item_valid),
      .item       (item)
   );

   // a byte is processed when it moves into the result register
   assign step_en = item_valid & advance;

   bbc_engine #(
      .STACK_DEPTH (STACK_DEPTH)
   ) u_engine (
      .clock          (clock),
      .reset          (reset),
      .step_en        (step_en),
      .item           (item),
      .square_enabled (square_enabled),
      .result         (result)
   );

   bbc_out_reg u_out_reg (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (item_valid),
      .result     (result),
      .advance    (advance),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

`ifndef SYNTHESIS
   localparam int FULL_DEPTH = (STACK_DEPTH > DEPTH_SAT) ? DEPTH_SAT : STACK_DEPTH;

   logic [2:0]         rsp_status;
   logic [DEPTH_W-1:0] rsp_depth;

   assign rsp_status = rsp_tdata[2:0];
   assign rsp_depth  = rsp_tdata[DEPTH_W+2:3];

   // a balanced text ends with an empty stack
   a_balanced_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_status == STATUS_BALANCED) |-> rsp_depth == '0)
      else $error("balanced verdict with open brackets");

   // an unclosed text ends with something on the stack
   a_unclosed_nonempty: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_status == STATUS_UNCLOSED) |-> rsp_depth != '0)
      else $error("unclosed verdict with empty stack");

   // overflow leaves the stack frozen full
   a_overflow_full: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_status == STATUS_OVERFLOW) |->
         rsp_depth == DEPTH_W'(FULL_DEPTH))
      else $error("overflow reported below full depth");

   // a held input byte waits unchanged while the result side stalls
   a_in_hold: assert property (@(posedge clock) disable iff (reset)
      item_valid && !advance |=> item_valid && $stable(item))
      else $error("input register lost a stalled byte");
`endif

endmodule

`default_nettype wire
